>>> hw/rtl/samls_pkg.sv
// Shared types, character codes and helpers for the SAM line statistics unit.
// No dependencies; imported by samls_line_state and the top level.
`default_nettype none

package samls_pkg;

  localparam logic [7:0] CHAR_AT    = 8'h40;
  localparam logic [7:0] CHAR_STAR  = 8'h2A;
  localparam logic [7:0] CHAR_EQ    = 8'h3D;
  localparam logic [7:0] CHAR_M     = 8'h4D;
  localparam logic [7:0] CHAR_X     = 8'h58;
  localparam logic [7:0] CHAR_I     = 8'h49;
  localparam logic [7:0] CHAR_D     = 8'h44;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [3:0] FIELD_FLAG  = 4'd1;
  localparam logic [3:0] FIELD_POS   = 4'd3;
  localparam logic [3:0] FIELD_MAPQ  = 4'd4;
  localparam logic [3:0] FIELD_CIGAR = 4'd5;
  localparam logic [3:0] FIELD_SEQ   = 4'd9;
  localparam logic [3:0] FIELD_QUAL  = 4'd10;
  localparam logic [3:0] FIELD_LAST  = 4'd15;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [39:0] SAT40 = 40'hFF_FFFF_FFFF;
  localparam logic [15:0] SAT16 = 16'hFFFF;
  localparam logic [7:0]  SAT8  = 8'hFF;

  localparam logic [7:0] QUAL_OFFSET_RESET = 8'd33;

  localparam int unsigned CNT_KINDS = 4;

  typedef enum logic [2:0] {
    OP_MATCH = 3'd0,
    OP_MISM  = 3'd1,
    OP_INS   = 3'd2,
    OP_DEL   = 3'd3,
    OP_SOFT  = 3'd4,
    OP_NONE  = 3'd5
  } cigar_op_e;

  typedef struct packed {
    logic        is_header;
    logic [15:0] flag;
    logic [31:0] start;
    logic [7:0]  mapq;
    logic [31:0] rl_sum;
    logic [31:0] al_sum;
    logic [31:0] match;
    logic [31:0] mism;
    logic [31:0] ins;
    logic [31:0] del;
    logic [31:0] seq_len;
    logic        seq_absent;
    logic [39:0] quality;
  } line_stats_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? SAT32 : s[31:0];
  endfunction

  function automatic cigar_op_e decode_op(input logic [7:0] c);
    cigar_op_e op;
    unique case (c)
      CHAR_EQ, CHAR_M: op = OP_MATCH;
      CHAR_X:          op = OP_MISM;
      CHAR_I:          op = OP_INS;
      CHAR_D:          op = OP_DEL;
      CHAR_S:          op = OP_SOFT;
      default:         op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sam_line_alignment_stats_unit.sv
// Top level of the SAM line statistics unit: handshakes, offset register, result register.
// Depends on samls_pkg and samls_line_state.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o, text_byte_i) takes one character of
//   tab-separated SAM text per item; a newline closes the line.
//   Output channel (out_valid_o/out_ready_i) gives one record per newline:
//   flag, zero-based start and end, mapping quality, read and aligned length,
//   CIGAR counts and quality sum. Header lines ('@') give is_header_o only.
//   cfg_we_i/cfg_data_i write the quality offset; write it only while idle.
// Timing:
//   One byte per cycle unless a newline is held off. The record for a line is valid in the
//   cycle after its newline is accepted and is held in one result register.
// Stall:
//   While a record waits on out_ready_i, non-newline bytes keep flowing into
//   the parser; a newline is held off until the result register frees.
// Reset:
//   Quality offset returns to 33, line state clears, the output goes empty.
`default_nettype none

module sam_line_alignment_stats_unit
  import samls_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  text_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             is_header_o,
  output logic [15:0]      flag_bits_o,
  output logic [31:0]      ref_start_o,
  output logic [7:0]       map_quality_o,
  output logic [31:0]      ref_end_o,
  output logic [31:0]      read_length_o,
  output logic [31:0]      aligned_length_o,
  output logic [31:0]      match_count_o,
  output logic [31:0]      mismatch_count_o,
  output logic [31:0]      insert_count_o,
  output logic [31:0]      delete_count_o,
  output logic [39:0]      quality_sum_o
);

  logic [7:0]  qual_offset_q;
  logic        out_valid_q, out_valid_d;
  logic        fire;
  logic        nl_fire;
  line_stats_t stats;

  logic [32:0] end_sum;
  logic [31:0] end_val;
  logic [31:0] rl_val;

  logic        is_header_q;
  logic [15:0] flag_q;
  logic [31:0] start_q;
  logic [7:0]  mapq_q;
  logic [31:0] end_q;
  logic [31:0] rl_q;
  logic [31:0] al_q;
  logic [31:0] match_q;
  logic [31:0] mism_q;
  logic [31:0] ins_q;
  logic [31:0] del_q;
  logic [39:0] qsum_q;

  assign in_ready_o = !out_valid_q || out_ready_i || (text_byte_i != CHAR_NL);
  assign fire       = in_valid_i && in_ready_o;
  assign nl_fire    = fire && (text_byte_i == CHAR_NL);

  samls_line_state u_line_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .byte_i        (text_byte_i),
    .qual_offset_i (qual_offset_q),
    .stats_o       (stats)
  );

  assign end_sum = {1'b0, stats.start} + {1'b0, stats.al_sum} - 33'd1;
  assign end_val = (stats.al_sum == 32'd0) ? stats.start :
                   end_sum[32] ? SAT32 : end_sum[31:0];
  assign rl_val  = (stats.rl_sum == 32'd0 && !stats.seq_absent) ? stats.seq_len
                                                               : stats.rl_sum;

  assign out_valid_d = nl_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qual_offset_q <= QUAL_OFFSET_RESET;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) qual_offset_q <= cfg_data_i;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (nl_fire) begin
      if (stats.is_header) begin
        is_header_q <= 1'b1;
        flag_q      <= '0;
        start_q     <= '0;
        mapq_q      <= '0;
        end_q       <= '0;
        rl_q        <= '0;
        al_q        <= '0;
        match_q     <= '0;
        mism_q      <= '0;
        ins_q       <= '0;
        del_q       <= '0;
        qsum_q      <= '0;
      end else begin
        is_header_q <= 1'b0;
        flag_q      <= stats.flag;
        start_q     <= stats.start;
        mapq_q      <= stats.mapq;
        end_q       <= end_val;
        rl_q        <= rl_val;
        al_q        <= stats.al_sum;
        match_q     <= stats.match;
        mism_q      <= stats.mism;
        ins_q       <= stats.ins;
        del_q       <= stats.del;
        qsum_q      <= stats.seq_absent ? 40'd0 : stats.quality;
      end
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_header_o      = is_header_q;
  assign flag_bits_o      = flag_q;
  assign ref_start_o      = start_q;
  assign map_quality_o    = mapq_q;
  assign ref_end_o        = end_q;
  assign read_length_o    = rl_q;
  assign aligned_length_o = al_q;
  assign match_count_o    = match_q;
  assign mismatch_count_o = mism_q;
  assign insert_count_o   = ins_q;
  assign delete_count_o   = del_q;
  assign quality_sum_o    = qsum_q;

  a_nl_gives_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nl_fire |=> out_valid_o)
    else $error("newline accepted without a result item");

  a_header_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_header_o) |->
      (flag_bits_o == 16'd0 && ref_end_o == 32'd0 && quality_sum_o == 40'd0))
    else $error("header item carries nonzero fields");

  a_end_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_header_o) |-> (ref_end_o >= ref_start_o))
    else $error("end position before start position");

  a_aligned_covers_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (aligned_length_o >= match_count_o))
    else $error("aligned length below match count");

endmodule

`default_nettype wire

>>> hw/rtl/samls_line_state.sv
// Per-line parser state: field tracking, decimal and CIGAR accumulation, quality sum.
// Depends on samls_pkg; presents field-closed line totals to the top level.
`default_nettype none

module samls_line_state
  import samls_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic [7:0]  qual_offset_i,
  output line_stats_t      stats_o
);

  logic [3:0]  field_q, field_d;
  logic        line_start_q, line_start_d;
  logic        header_q, header_d;
  logic [31:0] acc_q, acc_d;
  logic [15:0] flag_q, flag_d;
  logic [31:0] start_q, start_d;
  logic [7:0]  mapq_q, mapq_d;
  logic [31:0] cnt_q [CNT_KINDS];
  logic [31:0] cnt_d [CNT_KINDS];
  logic [31:0] rl_q, rl_d;
  logic [31:0] al_q, al_d;
  logic [31:0] seq_len_q, seq_len_d;
  logic        seq_absent_q, seq_absent_d;
  logic [39:0] qacc_q, qacc_d;
  logic        qfs_q, qfs_d;

  logic        header_now;
  logic        is_digit;
  logic [35:0] acc_wide;
  logic [31:0] digit_acc;
  logic [15:0] flag_close;
  logic [31:0] start_close;
  logic [7:0]  mapq_close;
  logic [39:0] qual_close;
  logic [8:0]  q_diff;
  logic [7:0]  q_val;
  logic [40:0] q_sum;
  cigar_op_e   op;

  assign header_now = header_q | (line_start_q & (byte_i == CHAR_AT));
  assign is_digit   = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign acc_wide   = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                    + {32'd0, byte_i[3:0]};
  assign digit_acc  = (acc_wide[35:32] != 4'd0) ? SAT32 : acc_wide[31:0];

  assign flag_close  = (field_q != FIELD_FLAG) ? flag_q :
                       (acc_q[31:16] != 16'd0) ? SAT16 : acc_q[15:0];
  assign start_close = (field_q != FIELD_POS) ? start_q :
                       acc_q - {31'd0, (acc_q != 32'd0)};
  assign mapq_close  = (field_q != FIELD_MAPQ) ? mapq_q :
                       (acc_q[31:8] != 24'd0) ? SAT8 : acc_q[7:0];
  assign qual_close  = ((field_q == FIELD_QUAL) && (acc_q == 32'd1) && qfs_q) ? 40'd0 : qacc_q;

  assign q_diff = {1'b0, byte_i} - {1'b0, qual_offset_i};
  assign q_val  = q_diff[8] ? 8'd0 : q_diff[7:0];
  assign q_sum  = {1'b0, qacc_q} + {33'd0, q_val};
  assign op     = decode_op(byte_i);

  always_comb begin
    field_d      = field_q;
    line_start_d = line_start_q;
    header_d     = header_q;
    acc_d        = acc_q;
    flag_d       = flag_q;
    start_d      = start_q;
    mapq_d       = mapq_q;
    cnt_d        = cnt_q;
    rl_d         = rl_q;
    al_d         = al_q;
    seq_len_d    = seq_len_q;
    seq_absent_d = seq_absent_q;
    qacc_d       = qacc_q;
    qfs_d        = qfs_q;
    if (fire_i) begin
      if (byte_i == CHAR_NL) begin
        field_d      = '0;
        line_start_d = 1'b1;
        header_d     = 1'b0;
        acc_d        = '0;
        flag_d       = '0;
        start_d      = '0;
        mapq_d       = '0;
        for (int k = 0; k < CNT_KINDS; k++) begin
          cnt_d[k] = '0;
        end
        rl_d         = '0;
        al_d         = '0;
        seq_len_d    = '0;
        seq_absent_d = 1'b0;
        qacc_d       = '0;
        qfs_d        = 1'b0;
      end else begin
        line_start_d = 1'b0;
        header_d     = header_now;
        if (!header_now) begin
          if (byte_i == CHAR_TAB) begin
            flag_d  = flag_close;
            start_d = start_close;
            mapq_d  = mapq_close;
            qacc_d  = qual_close;
            acc_d   = '0;
            qfs_d   = 1'b0;
            field_d = (field_q == FIELD_LAST) ? FIELD_LAST : field_q + 4'd1;
          end else begin
            unique case (field_q)
              FIELD_FLAG, FIELD_POS, FIELD_MAPQ: begin
                if (is_digit) acc_d = digit_acc;
              end
              FIELD_CIGAR: begin
                if (is_digit) begin
                  acc_d = digit_acc;
                end else if (byte_i > CHAR_SPACE) begin
                  acc_d = '0;
                  if (op == OP_MATCH || op == OP_MISM || op == OP_INS || op == OP_DEL) begin
                    cnt_d[op[1:0]] = sat_add32(cnt_q[op[1:0]], acc_q);
                  end
                  if (op == OP_MATCH || op == OP_MISM || op == OP_INS || op == OP_SOFT) begin
                    rl_d = sat_add32(rl_q, acc_q);
                  end
                  if (op == OP_MATCH || op == OP_MISM || op == OP_DEL) begin
                    al_d = sat_add32(al_q, acc_q);
                  end
                end
              end
              FIELD_SEQ: begin
                if (seq_len_q == 32'd0 && byte_i == CHAR_STAR) seq_absent_d = 1'b1;
                seq_len_d = sat_add32(seq_len_q, 32'd1);
              end
              FIELD_QUAL: begin
                if (acc_q == 32'd0 && byte_i == CHAR_STAR) qfs_d = 1'b1;
                qacc_d = q_sum[40] ? SAT40 : q_sum[39:0];
                acc_d  = sat_add32(acc_q, 32'd1);
              end
              default: begin
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_q      <= '0;
      line_start_q <= 1'b1;
      header_q     <= 1'b0;
      acc_q        <= '0;
      flag_q       <= '0;
      start_q      <= '0;
      mapq_q       <= '0;
      for (int k = 0; k < CNT_KINDS; k++) begin
        cnt_q[k] <= '0;
      end
      rl_q         <= '0;
      al_q         <= '0;
      seq_len_q    <= '0;
      seq_absent_q <= 1'b0;
      qacc_q       <= '0;
      qfs_q        <= 1'b0;
    end else begin
      field_q      <= field_d;
      line_start_q <= line_start_d;
      header_q     <= header_d;
      acc_q        <= acc_d;
      flag_q       <= flag_d;
      start_q      <= start_d;
      mapq_q       <= mapq_d;
      cnt_q        <= cnt_d;
      rl_q         <= rl_d;
      al_q         <= al_d;
      seq_len_q    <= seq_len_d;
      seq_absent_q <= seq_absent_d;
      qacc_q       <= qacc_d;
      qfs_q        <= qfs_d;
    end
  end

  always_comb begin
    stats_o            = '0;
    stats_o.is_header  = header_q;
    stats_o.flag       = flag_close;
    stats_o.start      = start_close;
    stats_o.mapq       = mapq_close;
    stats_o.rl_sum     = rl_q;
    stats_o.al_sum     = al_q;
    stats_o.match      = cnt_q[2'(OP_MATCH)];
    stats_o.mism       = cnt_q[2'(OP_MISM)];
    stats_o.ins        = cnt_q[2'(OP_INS)];
    stats_o.del        = cnt_q[2'(OP_DEL)];
    stats_o.seq_len    = seq_len_q;
    stats_o.seq_absent = seq_absent_q;
    stats_o.quality    = qual_close;
  end

endmodule

`default_nettype wire

>>> test/tb_sam_line_alignment_stats_unit.sv
// Testbench for sam_line_alignment_stats_unit: streams SAM text bytes and checks every line record.
// Holds its own line-statistics predictor and scoreboard class; depends on samls_pkg and the RTL.
module tb_sam_line_alignment_stats_unit;
  import samls_pkg::*;

  typedef struct packed {
    logic        is_header;
    logic [15:0] flag_bits;
    logic [31:0] ref_start;
    logic [7:0]  map_quality;
    logic [31:0] ref_end;
    logic [31:0] read_length;
    logic [31:0] aligned_length;
    logic [31:0] match_count;
    logic [31:0] mismatch_count;
    logic [31:0] insert_count;
    logic [31:0] delete_count;
    logic [39:0] quality_sum;
  } sam_record_t;

  class line_stats_board;
    int          errors;
    int          bytes_seen;
    int          records_done;
    int          header_records;
    sam_record_t expected_records[$];

    bit [7:0]  qual_offset;
    bit [3:0]  field_idx;
    bit        at_line_start;
    bit        in_header;
    bit [31:0] num_acc;
    bit [15:0] flag_r;
    bit [31:0] start_r;
    bit [7:0]  mapq_r;
    bit [31:0] op_total[5];
    bit [31:0] seq_len;
    bit        seq_star;
    bit [39:0] qual_acc;
    bit        qual_star;

    function new();
      qual_offset = QUAL_OFFSET_RESET;
      clear_line();
    endfunction

    function int pending();
      return expected_records.size();
    endfunction

    function void set_offset(bit [7:0] v);
      qual_offset = v;
    endfunction

    function bit [31:0] clamp_add(bit [31:0] a, bit [31:0] b);
      bit [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s > {1'b0, SAT32}) ? SAT32 : s[31:0];
    endfunction

    function void clear_line();
      field_idx = 0;
      at_line_start = 1;
      in_header = 0;
      num_acc = 0;
      flag_r = 0;
      start_r = 0;
      mapq_r = 0;
      foreach (op_total[k]) op_total[k] = 0;
      seq_len = 0;
      seq_star = 0;
      qual_acc = 0;
      qual_star = 0;
    endfunction

    function void push_digit(bit [7:0] c);
      bit [35:0] v;
      v = {4'b0, num_acc} * 36'd10 + 36'(c - CHAR_ZERO);
      num_acc = (v > 36'(SAT32)) ? SAT32 : v[31:0];
    endfunction

    function void close_field();
      case (field_idx)
        FIELD_FLAG: flag_r = (num_acc > 32'd65535) ? 16'hFFFF : num_acc[15:0];
        FIELD_POS:  start_r = (num_acc != 0) ? num_acc - 32'd1 : 32'd0;
        FIELD_MAPQ: mapq_r = (num_acc > 32'd255) ? 8'hFF : num_acc[7:0];
        FIELD_QUAL: if (num_acc == 32'd1 && qual_star) qual_acc = 0;
        default: ;
      endcase
      num_acc = 0;
    endfunction

    function void add_op(bit [7:0] c);
      cigar_op_e k;
      case (c)
        CHAR_EQ, CHAR_M: k = OP_MATCH;
        CHAR_X:          k = OP_MISM;
        CHAR_I:          k = OP_INS;
        CHAR_D:          k = OP_DEL;
        CHAR_S:          k = OP_SOFT;
        default:         k = OP_NONE;
      endcase
      if (k != OP_NONE) op_total[k] = clamp_add(op_total[k], num_acc);
      num_acc = 0;
    endfunction

    function void note_text_byte(bit [7:0] c);
      sam_record_t rec;
      bit [31:0]   rl;
      bit [31:0]   al;
      bit [32:0]   last;
      bit [40:0]   qsum;
      bit [7:0]    qbyte;
      bytes_seen++;
      if (c == CHAR_NL) begin
        rec = '0;
        if (in_header) begin
          rec.is_header = 1'b1;
          header_records++;
        end else begin
          close_field();
          rl = clamp_add(clamp_add(op_total[OP_MATCH], op_total[OP_MISM]),
                         clamp_add(op_total[OP_INS], op_total[OP_SOFT]));
          if (rl == 0 && !seq_star) rl = seq_len;
          al = clamp_add(clamp_add(op_total[OP_MATCH], op_total[OP_MISM]), op_total[OP_DEL]);
          if (al == 0) begin
            rec.ref_end = start_r;
          end else begin
            last = {1'b0, start_r} + {1'b0, al} - 33'd1;
            rec.ref_end = last[32] ? SAT32 : last[31:0];
          end
          rec.flag_bits      = flag_r;
          rec.ref_start      = start_r;
          rec.map_quality    = mapq_r;
          rec.read_length    = rl;
          rec.aligned_length = al;
          rec.match_count    = op_total[OP_MATCH];
          rec.mismatch_count = op_total[OP_MISM];
          rec.insert_count   = op_total[OP_INS];
          rec.delete_count   = op_total[OP_DEL];
          rec.quality_sum    = seq_star ? 40'd0 : qual_acc;
        end
        expected_records.push_back(rec);
        clear_line();
        return;
      end
      if (at_line_start) begin
        at_line_start = 0;
        if (c == CHAR_AT) in_header = 1;
      end
      if (in_header) return;
      if (c == CHAR_TAB) begin
        close_field();
        if (field_idx != FIELD_LAST) field_idx++;
        qual_star = 0;
        return;
      end
      case (field_idx)
        FIELD_FLAG, FIELD_POS, FIELD_MAPQ: begin
          if (c >= CHAR_ZERO && c <= CHAR_NINE) push_digit(c);
        end
        FIELD_CIGAR: begin
          if (c >= CHAR_ZERO && c <= CHAR_NINE) push_digit(c);
          else if (c > CHAR_SPACE) add_op(c);
        end
        FIELD_SEQ: begin
          if (seq_len == 0 && c == CHAR_STAR) seq_star = 1;
          seq_len = clamp_add(seq_len, 32'd1);
        end
        FIELD_QUAL: begin
          if (num_acc == 0 && c == CHAR_STAR) qual_star = 1;
          qbyte = (c >= qual_offset) ? c - qual_offset : 8'd0;
          qsum = {1'b0, qual_acc} + 41'(qbyte);
          qual_acc = (qsum > 41'(SAT40)) ? SAT40 : qsum[39:0];
          num_acc = clamp_add(num_acc, 32'd1);
        end
        default: ;
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task cmp(string name, logic [39:0] got, logic [39:0] want);
      if (got !== want)
        report($sformatf("record %0d %s got %0h want %0h", records_done, name, got, want));
    endtask

    task check_record(sam_record_t got);
      sam_record_t want;
      if (expected_records.size() == 0) begin
        report("record arrived with none expected");
        return;
      end
      want = expected_records.pop_front();
      records_done++;
      cmp("is_header", got.is_header, want.is_header);
      cmp("flag_bits", got.flag_bits, want.flag_bits);
      cmp("ref_start", got.ref_start, want.ref_start);
      cmp("map_quality", got.map_quality, want.map_quality);
      cmp("ref_end", got.ref_end, want.ref_end);
      cmp("read_length", got.read_length, want.read_length);
      cmp("aligned_length", got.aligned_length, want.aligned_length);
      cmp("match_count", got.match_count, want.match_count);
      cmp("mismatch_count", got.mismatch_count, want.mismatch_count);
      cmp("insert_count", got.insert_count, want.insert_count);
      cmp("delete_count", got.delete_count, want.delete_count);
      cmp("quality_sum", got.quality_sum, want.quality_sum);
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  text_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        is_header_o;
  logic [15:0] flag_bits_o;
  logic [31:0] ref_start_o;
  logic [7:0]  map_quality_o;
  logic [31:0] ref_end_o;
  logic [31:0] read_length_o;
  logic [31:0] aligned_length_o;
  logic [31:0] match_count_o;
  logic [31:0] mismatch_count_o;
  logic [31:0] insert_count_o;
  logic [31:0] delete_count_o;
  logic [39:0] quality_sum_o;

  line_stats_board sb;
  logic [7:0]      line_q[$];
  int              send_idle_pct;
  int              recv_stall_pct;
  int              lines_sent;

  sam_line_alignment_stats_unit i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .text_byte_i      (text_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_header_o      (is_header_o),
    .flag_bits_o      (flag_bits_o),
    .ref_start_o      (ref_start_o),
    .map_quality_o    (map_quality_o),
    .ref_end_o        (ref_end_o),
    .read_length_o    (read_length_o),
    .aligned_length_o (aligned_length_o),
    .match_count_o    (match_count_o),
    .mismatch_count_o (mismatch_count_o),
    .insert_count_o   (insert_count_o),
    .delete_count_o   (delete_count_o),
    .quality_sum_o    (quality_sum_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor_b
    sam_record_t got;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_text_byte(text_byte_i);
      if (out_valid_o && out_ready_i) begin
        got.is_header      = is_header_o;
        got.flag_bits      = flag_bits_o;
        got.ref_start      = ref_start_o;
        got.map_quality    = map_quality_o;
        got.ref_end        = ref_end_o;
        got.read_length    = read_length_o;
        got.aligned_length = aligned_length_o;
        got.match_count    = match_count_o;
        got.mismatch_count = mismatch_count_o;
        got.insert_count   = insert_count_o;
        got.delete_count   = delete_count_o;
        got.quality_sum    = quality_sum_o;
        sb.check_record(got);
      end
    end
  end

  initial begin
    #6000000;
    $display("TIMEOUT: %0d records still expected", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  task send_byte(input logic [7:0] b);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task send_line();
    foreach (line_q[i]) send_byte(line_q[i]);
    lines_sent++;
  endtask

  task send_text(input string s);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    send_line();
  endtask

  task put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task put_num(input longint unsigned v);
    put_text($sformatf("%0d", v));
  endtask

  task put_digits(input int n);
    for (int i = 0; i < n; i++) line_q.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task put_rand(input int n, input int lo, input int hi);
    logic [7:0] b;
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(hi, lo));
      if (b == CHAR_NL || b == CHAR_TAB) b = CHAR_STAR;
      line_q.push_back(b);
    end
  endtask

  task build_alignment();
    string bases;
    string ops;
    int    seq_n;
    int    n_ops;
    bases = "ACGTN";
    ops = "=MXIDSNHP*";
    put_rand($urandom_range(1, 6), "a", "z");
    put_text("\t");
    if ($urandom_range(0, 9) == 0) put_digits($urandom_range(5, 12));
    else put_num($urandom_range(0, 4095));
    put_text("\tchr");
    put_digits(1);
    put_text("\t");
    case ($urandom_range(0, 9))
      0: put_text("0");
      1: put_num(64'hFFFF_FFFF - $urandom_range(0, 3));
      2: put_digits($urandom_range(10, 12));
      default: put_num($urandom_range(1, 100000));
    endcase
    put_text("\t");
    case ($urandom_range(0, 9))
      0: put_num($urandom_range(250, 260));
      1: put_digits($urandom_range(4, 11));
      default: put_num($urandom_range(0, 60));
    endcase
    put_text("\t");
    if ($urandom_range(0, 6) == 0) begin
      put_text("*");
    end else begin
      n_ops = $urandom_range(1, 5);
      for (int i = 0; i < n_ops; i++) begin
        if ($urandom_range(0, 15) == 0) put_digits(10);
        else put_num($urandom_range(1, 50));
        line_q.push_back(ops[$urandom_range(0, ops.len() - 1)]);
      end
    end
    put_text("\t*\t0\t0\t");
    seq_n = $urandom_range(0, 12);
    if ($urandom_range(0, 6) == 0) put_text("*");
    else for (int i = 0; i < seq_n; i++) line_q.push_back(bases[$urandom_range(0, 4)]);
    put_text("\t");
    case ($urandom_range(0, 9))
      0: put_text("*");
      1: put_rand(seq_n, 0, 255);
      2: put_rand($urandom_range(0, 12), 33, 74);
      default: put_rand(seq_n, 33, 74);
    endcase
    if ($urandom_range(0, 2) == 0) begin
      put_text("\tNM:i:");
      put_num($urandom_range(0, 9));
    end
  endtask

  task build_random_line();
    int keep;
    logic [7:0] b;
    line_q.delete();
    case ($urandom_range(0, 19))
      0, 1: begin
        put_text("@HD");
        put_rand($urandom_range(0, 12), 32, 126);
        if ($urandom_range(0, 1) == 0) put_text("\tVN:1.6");
      end
      2: ;
      3, 4: begin
        for (int i = $urandom_range(1, 30); i > 0; i--) begin
          b = 8'($urandom_range(0, 255));
          if (b == CHAR_NL) b = CHAR_TAB;
          line_q.push_back(b);
        end
      end
      5, 6: begin
        build_alignment();
        keep = $urandom_range(0, line_q.size());
        while (line_q.size() > keep) void'(line_q.pop_back());
      end
      default: build_alignment();
    endcase
    line_q.push_back(CHAR_NL);
  endtask

  task drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task write_offset(input logic [7:0] v);
    cfg_data_i <= v;
    cfg_we_i   <= 1'b1;
    sb.set_offset(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic [7:0] offsets[8];
    int         phase_start;
    int         phase_lines;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = 8'd0;
    in_valid_i = 1'b0;
    text_byte_i = 8'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    lines_sent = 0;
    offsets = '{8'd0, 8'd255, 8'd33, 8'd64, 8'($urandom), 8'd1, 8'd254, 8'($urandom)};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_text("@HD\tVN:1.6\n");
    send_text("\n");
    send_text("@\n");
    send_text("r1\t99\tchr1\t100\t60\t5=3M2X1I4D2S3N1H1P\t*\t0\t0\tACGTACGTACGTAC\tIIIIIIIIIIIIII\tNM:i:1\n");
    send_text("r2\t4\t*\t0\t0\t*\t*\t0\t0\t*\t*\n");
    send_text("r3\t99999\tc\t4294967295\t999\t4294967295M4294967295M\t*\t0\t0\tAC\t*\n");
    send_text("r4\t1x6\tc\t1\t2\t10M\t*\t0\t0\t\t\n");
    send_text("r5\t0\tc\t5\t0\t*\t*\t0\t0\tACGT\t**!~\n");
    send_text("r6\t0\tc\t1\t0\t3 M2D5\t*\t0\t0\tA\t5\n");
    send_text("x@\t16\tc\t7\n");
    send_text("a\tb\tc\td\te\tf\tg\th\ti\tj\tk\tl\tm\tn\to\tp\tq\tr\n");
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_offset(offsets[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
        default: begin send_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      phase_start = sb.bytes_seen;
      phase_lines = 0;
      while (sb.bytes_seen - phase_start < 40 || phase_lines < 2) begin
        build_random_line();
        send_line();
        phase_lines++;
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    while (sb.pending() != 0) begin
      sb.report("expected record never arrived");
      void'(sb.expected_records.pop_front());
    end
    $display("Streamed %0d text bytes in %0d lines; checked %0d records (%0d headers)",
             sb.bytes_seen, lines_sent, sb.records_done, sb.header_records);
    $display("Covered the reset quality offset, 8 written offsets and 4 idle/stall patterns");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
